// ===== hw/rtl/rsla_pkg.sv =====
`default_nettype none
package rsla_pkg;

	localparam int SLOTS = 12;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int SNAKE_LEN = 12;

	localparam logic [7:0] CMD_SET_SLOT = 8'h01;
	localparam logic [7:0] CMD_CLEAR = 8'h02;
	localparam logic [7:0] CMD_BRIGHT = 8'h03;
	localparam logic [7:0] CMD_MODE = 8'h10;
	localparam logic [7:0] CMD_PING = 8'h7E;

	localparam logic [1:0] MODE_STATIC = 2'd0;
	localparam logic [1:0] MODE_BLINK = 2'd1;
	localparam logic [1:0] MODE_BREATHE = 2'd2;

	localparam logic [7:0] BRIGHT_RESET = 8'd160;
	localparam logic [7:0] PROTO_VERSION = 8'd1;

	localparam logic KIND_PONG = 1'b0;
	localparam logic KIND_LED = 1'b1;

	localparam logic [3:0] SNAKE_MAP [SNAKE_LEN] = '{
		4'd3, 4'd2, 4'd1, 4'd0, 4'd4, 4'd5, 4'd6, 4'd7, 4'd11, 4'd10, 4'd9, 4'd8
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SCALE,
		ST_EMIT,
		ST_PONG
	} rsla_state_t;

	typedef struct packed {
		logic accept;
		logic load_s1;
		logic load_s2;
		logic load_out;
		logic pong_sel;
		logic slot_inc;
	} rsla_cmd_t;

	typedef struct packed {
		logic last_slot;
		logic out_free;
	} rsla_stat_t;

	// Exact floor(x / 255) for any product of two bytes.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] acc;
		acc = {1'b0, x} + 17'd1 + 17'(x[15:8]);
		return acc[15:8];
	endfunction

	// Residue modulo 3 by folding base-4 digits, since 4 is 1 modulo 3.
	function automatic logic [1:0] mod3(input logic [7:0] v);
		logic [3:0] s1;
		logic [2:0] s2;
		logic [1:0] r;
		s1 = 4'(v[7:6]) + 4'(v[5:4]) + 4'(v[3:2]) + 4'(v[1:0]);
		s2 = 3'(s1[3:2]) + 3'(s1[1:0]);
		case (s2) inside
			3'd0, 3'd3, 3'd6: r = 2'd0;
			3'd1, 3'd4: r = 2'd1;
			3'd2, 3'd5: r = 2'd2;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

	// Triangle wave over time bits 11:4: rises 0..254, then falls 254..0.
	function automatic logic [7:0] tri_wave(input logic [15:0] t);
		logic [7:0] w;
		w = t[11:4];
		return w[7] ? {~w[6:0], 1'b0} : {w[6:0], 1'b0};
	endfunction

	function automatic logic [3:0] snake(input logic [SLOT_W-1:0] i);
		logic [7:0] iw;
		iw = 8'(i);
		if (iw < 8'(SNAKE_LEN)) begin
			return SNAKE_MAP[iw[3:0]];
		end else begin
			return iw[3:0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/rsla_ctrl.sv =====
`default_nettype none
module rsla_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire logic                  func,
	input  wire logic [7:0]            cmd,
	input  wire rsla_pkg::rsla_stat_t  stat,
	output rsla_pkg::rsla_cmd_t        ctl
);

	rsla_pkg::rsla_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsla_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl = '0;
		item_stall = 1'b1;
		case (state_q)
			rsla_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					ctl.accept = 1'b1;
					if (func) begin
						state_d = rsla_pkg::ST_FETCH;
					end else if (cmd == rsla_pkg::CMD_PING) begin
						state_d = rsla_pkg::ST_PONG;
					end
				end
			end
			rsla_pkg::ST_FETCH: begin
				ctl.load_s1 = 1'b1;
				state_d = rsla_pkg::ST_SCALE;
			end
			rsla_pkg::ST_SCALE: begin
				ctl.load_s2 = 1'b1;
				state_d = rsla_pkg::ST_EMIT;
			end
			rsla_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					ctl.load_out = 1'b1;
					if (stat.last_slot) begin
						state_d = rsla_pkg::ST_IDLE;
					end else begin
						ctl.slot_inc = 1'b1;
						state_d = rsla_pkg::ST_FETCH;
					end
				end
			end
			rsla_pkg::ST_PONG: begin
				if (stat.out_free) begin
					ctl.load_out = 1'b1;
					ctl.pong_sel = 1'b1;
					state_d = rsla_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rsla_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rsla_datapath.sv =====
`default_nettype none
module rsla_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rsla_pkg::rsla_cmd_t  ctl,
	output rsla_pkg::rsla_stat_t      stat,
	input  wire logic                 func,
	input  wire logic [7:0]           cmd,
	input  wire logic [7:0]           arg1,
	input  wire logic [7:0]           arg2,
	input  wire logic [7:0]           arg3,
	input  wire logic [7:0]           arg4,
	input  wire logic [15:0]          time_ms,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic                      kind,
	output logic [3:0]                led_index,
	output logic [7:0]                red_out,
	output logic [7:0]                green_out,
	output logic [7:0]                blue_out,
	output logic [7:0]                echo_token,
	output logic [7:0]                proto_version,
	output logic [7:0]                led_total,
	output logic                      last
);

	logic [23:0] color_q [rsla_pkg::SLOTS];
	logic [1:0]  mode_q [rsla_pkg::SLOTS];
	logic [7:0]  bright_q;
	logic [15:0] time_q;
	logic [7:0]  token_q;
	logic [rsla_pkg::SLOT_W-1:0] slot_q;
	logic        valid_q;

	logic [23:0] color_s1;
	logic [1:0]  mode_s1;
	logic [15:0] prod_s1;
	logic        blink_off_s1;

	logic [15:0] red_s2, green_s2, blue_s2;
	logic [7:0]  scale_eff;

	logic cmd_beat;
	logic slot_ok;

	assign cmd_beat = ctl.accept && !func;
	assign slot_ok = arg1 < 8'(rsla_pkg::SLOTS);

	assign stat.last_slot = slot_q == rsla_pkg::SLOT_W'(rsla_pkg::SLOTS - 1);
	assign stat.out_free = !valid_q || !result_stall;
	assign result_valid = valid_q;

	// Slot store and global brightness; commands act on the accepting beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rsla_pkg::SLOTS; i++) begin
				color_q[i] <= '0;
				mode_q[i] <= rsla_pkg::MODE_STATIC;
			end
			bright_q <= rsla_pkg::BRIGHT_RESET;
		end else if (cmd_beat) begin
			case (cmd)
				rsla_pkg::CMD_SET_SLOT: begin
					if (slot_ok) begin
						color_q[arg1[rsla_pkg::SLOT_W-1:0]] <= {arg2, arg3, arg4};
					end
				end
				rsla_pkg::CMD_CLEAR: begin
					for (int i = 0; i < rsla_pkg::SLOTS; i++) begin
						color_q[i] <= '0;
						mode_q[i] <= rsla_pkg::MODE_STATIC;
					end
				end
				rsla_pkg::CMD_BRIGHT: begin
					bright_q <= arg1;
				end
				rsla_pkg::CMD_MODE: begin
					if (slot_ok) begin
						mode_q[arg1[rsla_pkg::SLOT_W-1:0]] <= rsla_pkg::mod3(arg2);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctl.accept) begin
			slot_q <= '0;
		end else if (ctl.slot_inc) begin
			slot_q <= slot_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			time_q <= time_ms;
			token_q <= arg1;
		end
	end

	// First step: fetch the slot and form the breathing product.
	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			color_s1 <= color_q[slot_q];
			mode_s1 <= mode_q[slot_q];
			prod_s1 <= 16'(bright_q) * 16'(rsla_pkg::tri_wave(time_q));
			blink_off_s1 <= !time_q[8];
		end
	end

	always_comb begin
		case (mode_s1)
			rsla_pkg::MODE_BLINK: scale_eff = blink_off_s1 ? 8'd0 : bright_q;
			rsla_pkg::MODE_BREATHE: scale_eff = rsla_pkg::div255(prod_s1);
			default: scale_eff = bright_q;
		endcase
	end

	// Second step: scale the three channels by the effective brightness.
	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			red_s2 <= 16'(color_s1[23:16]) * 16'(scale_eff);
			green_s2 <= 16'(color_s1[15:8]) * 16'(scale_eff);
			blue_s2 <= 16'(color_s1[7:0]) * 16'(scale_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			if (ctl.pong_sel) begin
				kind <= rsla_pkg::KIND_PONG;
				led_index <= '0;
				red_out <= '0;
				green_out <= '0;
				blue_out <= '0;
				echo_token <= token_q;
				proto_version <= rsla_pkg::PROTO_VERSION;
				led_total <= 8'(rsla_pkg::SLOTS);
				last <= 1'b1;
			end else begin
				kind <= rsla_pkg::KIND_LED;
				led_index <= rsla_pkg::snake(slot_q);
				red_out <= rsla_pkg::div255(red_s2);
				green_out <= rsla_pkg::div255(green_s2);
				blue_out <= rsla_pkg::div255(blue_s2);
				echo_token <= '0;
				proto_version <= '0;
				led_total <= '0;
				last <= stat.last_slot;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/rgb_slot_led_animator.sv =====
// Channel   Direction  Handshake                   Payload
// item      in         item_valid / item_stall     func cmd arg1 arg2 arg3 arg4 time_ms
// result    out        result_valid / result_stall kind led_index red_out green_out
//                                                  blue_out echo_token proto_version
//                                                  led_total last
//
// A command beat is taken in the idle state; a ping then goes through the pong
// state to load its pong. A refresh beat yields twelve LED beats, each passing
// through the fetch, scale and emit states in turn.
// Result stalls hold the emit and pong steps; the next item is taken once the
// final beat of the current item is in the output register.
// After reset every slot is black and static and the brightness is 160.
`default_nettype none
module rgb_slot_led_animator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic        func,
	input  wire logic [7:0]  cmd,
	input  wire logic [7:0]  arg1,
	input  wire logic [7:0]  arg2,
	input  wire logic [7:0]  arg3,
	input  wire logic [7:0]  arg4,
	input  wire logic [15:0] time_ms,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic             kind,
	output logic [3:0]       led_index,
	output logic [7:0]       red_out,
	output logic [7:0]       green_out,
	output logic [7:0]       blue_out,
	output logic [7:0]       echo_token,
	output logic [7:0]       proto_version,
	output logic [7:0]       led_total,
	output logic             last
);

	rsla_pkg::rsla_cmd_t  ctl;
	rsla_pkg::rsla_stat_t stat;

	rsla_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.func       (func),
		.cmd        (cmd),
		.stat       (stat),
		.ctl        (ctl)
	);

	rsla_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.func          (func),
		.cmd           (cmd),
		.arg1          (arg1),
		.arg2          (arg2),
		.arg3          (arg3),
		.arg4          (arg4),
		.time_ms       (time_ms),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.led_index     (led_index),
		.red_out       (red_out),
		.green_out     (green_out),
		.blue_out      (blue_out),
		.echo_token    (echo_token),
		.proto_version (proto_version),
		.led_total     (led_total),
		.last          (last)
	);

endmodule
`default_nettype wire
